/* sv/assert_macros.svh */
// assertion macros shared by the bar builder rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/mtf_ohlc_pkg.sv */
// types, constants and helpers for the multi-timeframe ohlc bar builder
// no dependencies
`default_nettype none

package mtf_ohlc_pkg;

  localparam int TIME_BITS      = 17;
  localparam int PRICE_IO_BITS  = 32;
  localparam int VOLUME_IN_BITS = 31;
  localparam int DELTA_BITS     = 32;
  localparam int COUNT_BITS     = 32;
  localparam int BAR_VOL_BITS   = 48;
  localparam int FRAME_BITS     = 2;
  localparam int MASK_BITS      = 3;
  localparam int KNOWN_FRAMES   = 4;

  localparam int NUM_FRAMES_DEF = 4;
  localparam int PRICE_BITS_DEF = 32;

  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;

  // reciprocal multiply: exact floor division for any 17-bit time
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_BITS  = 48;

  localparam logic [MASK_BITS-1:0] MASK_RESET = 3'b111;

  localparam logic KIND_BAR    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [BAR_VOL_BITS-1:0] VOL_MAX = {1'b0, {(BAR_VOL_BITS-1){1'b1}}};
  localparam logic [BAR_VOL_BITS-1:0] VOL_MIN = {1'b1, {(BAR_VOL_BITS-1){1'b0}}};

  typedef struct packed {
    logic [TIME_BITS-1:0]     tod;
    logic [PRICE_IO_BITS-1:0] price;
    logic [DELTA_BITS-1:0]    delta;
    logic                     unchanged;
    logic [TIME_BITS-1:0]     quot;
  } tok_t;

  typedef struct packed {
    logic                            kind;
    logic [FRAME_BITS-1:0]           frame;
    logic [TIME_BITS-1:0]            bar_start;
    logic [PRICE_IO_BITS-1:0]        open_price;
    logic [PRICE_IO_BITS-1:0]        high_price;
    logic [PRICE_IO_BITS-1:0]        low_price;
    logic [PRICE_IO_BITS-1:0]        close_price;
    logic [COUNT_BITS-1:0]           tick_count;
    logic signed [BAR_VOL_BITS-1:0]  bar_volume;
    logic                            volume_unchanged;
    logic                            last;
  } res_t;

  function automatic int frame_unit(input int f);
    int u;
    u = SEC_PER_MIN;
    unique case (f)
      0:       u = SEC_PER_MIN;
      1:       u = 5 * SEC_PER_MIN;
      2:       u = 15 * SEC_PER_MIN;
      3:       u = SEC_PER_HOUR;
      default: u = SEC_PER_MIN;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* sv/multi_timeframe_ohlc_bar_builder.sv */
// multi-timeframe ohlc bar builder top: entry stage, chain of frame cells, output register
// a tick walks the cell chain one frame per cycle while the output register is not stalled;
// closed bars and a status item follow, the status item once the tick leaves the last cell
// a new tick is taken only when the chain is empty or the last status item is leaving it
// reset: synchronous active low; clears open bars, previous volume, enable mask to 7
// depends on mtf_ohlc_pkg, mtf_ohlc_cell and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module multi_timeframe_ohlc_bar_builder import mtf_ohlc_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [MASK_BITS-1:0]           cfg_frame_enable_mask,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [TIME_BITS-1:0]           in_time_of_day,
  input  wire logic [PRICE_IO_BITS-1:0]       in_last_price,
  input  wire logic [VOLUME_IN_BITS-1:0]      in_total_volume,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_kind,
  output logic [FRAME_BITS-1:0]               out_frame,
  output logic [TIME_BITS-1:0]                out_bar_start,
  output logic [PRICE_IO_BITS-1:0]            out_open_price,
  output logic [PRICE_IO_BITS-1:0]            out_high_price,
  output logic [PRICE_IO_BITS-1:0]            out_low_price,
  output logic [PRICE_IO_BITS-1:0]            out_close_price,
  output logic [COUNT_BITS-1:0]               out_tick_count,
  output logic signed [BAR_VOL_BITS-1:0]      out_bar_volume,
  output logic                                out_volume_unchanged,
  output logic                                out_last
);

  localparam int UNIT0 = frame_unit(0);
  localparam logic [RECIP_BITS-1:0] RECIP0 =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(UNIT0) - 64'd1) / 64'(UNIT0));

  logic [MASK_BITS-1:0]      mask_r;
  logic [VOLUME_IN_BITS-1:0] prev_vol_r;
  logic                      front_vld_r;
  tok_t                      front_r;
  res_t                      out_r;
  logic                      out_valid_r;

  logic [NUM_FRAMES:0]       vld;
  tok_t                      tok_a [NUM_FRAMES+1];
  logic [NUM_FRAMES-1:0]     frame_en;
  logic [NUM_FRAMES-1:0]     emit_vld;
  res_t                      emit_a [NUM_FRAMES];

  logic                      adv;
  logic                      status_go;
  logic                      in_acc;
  logic [RECIP_BITS-1:0]     qprod0;
  tok_t                      entry_tok;
  res_t                      bar_sel;
  res_t                      status_item;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_ready;
  assign status_go = vld[NUM_FRAMES] && adv;
  assign in_ready  = !(|vld) || status_go;
  assign in_acc    = in_valid && in_ready;
  assign vld[0]    = front_vld_r;
  assign tok_a[0]  = front_r;

  always_comb begin
    qprod0              = RECIP_BITS'(in_time_of_day) * RECIP0;
    entry_tok.tod       = in_time_of_day;
    entry_tok.price     = in_last_price;
    entry_tok.delta     = DELTA_BITS'({1'b0, in_total_volume}) - DELTA_BITS'({1'b0, prev_vol_r});
    entry_tok.unchanged = (in_total_volume == prev_vol_r);
    entry_tok.quot      = qprod0[RECIP_SHIFT +: TIME_BITS];
  end

  for (genvar f = 0; f < NUM_FRAMES; f++) begin : g_cell
    if (f == 0) begin : g_base
      assign frame_en[f] = 1'b1;
    end else if (f < KNOWN_FRAMES) begin : g_masked
      assign frame_en[f] = mask_r[f-1];
    end else begin : g_unused
      assign frame_en[f] = 1'b0;
    end

    mtf_ohlc_cell #(
      .FRAME_IDX  (f),
      .PRICE_BITS (PRICE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .frame_en   (frame_en[f]),
      .tok_vld_in (vld[f]),
      .tok_in     (tok_a[f]),
      .tok_vld_r  (vld[f+1]),
      .tok_r      (tok_a[f+1]),
      .emit_vld   (emit_vld[f]),
      .emit       (emit_a[f])
    );
  end

  always_comb begin
    bar_sel = '0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      if (emit_vld[f]) begin
        bar_sel = bar_sel | emit_a[f];
      end
    end
    status_item                  = '0;
    status_item.kind             = KIND_STATUS;
    status_item.volume_unchanged = tok_a[NUM_FRAMES].unchanged;
    status_item.last             = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MASK_RESET;
      prev_vol_r  <= '0;
      front_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask_r <= cfg_frame_enable_mask;
      end
      if (in_acc) begin
        prev_vol_r  <= in_total_volume;
        front_vld_r <= 1'b1;
      end else if (adv) begin
        front_vld_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= status_go || (|emit_vld);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      front_r <= entry_tok;
    end
    if (adv) begin
      out_r <= status_go ? status_item : bar_sel;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_r.kind;
  assign out_frame            = out_r.frame;
  assign out_bar_start        = out_r.bar_start;
  assign out_open_price       = out_r.open_price;
  assign out_high_price       = out_r.high_price;
  assign out_low_price        = out_r.low_price;
  assign out_close_price      = out_r.close_price;
  assign out_tick_count       = out_r.tick_count;
  assign out_bar_volume       = out_r.bar_volume;
  assign out_volume_unchanged = out_r.volume_unchanged;
  assign out_last             = out_r.last;

  `ASSERT_CLK(a_single_tick_in_chain, $onehot0(vld), "more than one tick in the cell chain")
  `ASSERT_CLK(a_accept_enters_chain, in_acc |=> front_vld_r, "accepted tick missing at chain entry")
  `ASSERT_NEVER(a_emit_with_status, status_go && (|emit_vld), "bar closed while status leaves")

endmodule

`default_nettype wire

/* sv/mtf_ohlc_cell.sv */
// one frame of the bar chain: holds the open bar, closes and updates it
// depends on mtf_ohlc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mtf_ohlc_cell import mtf_ohlc_pkg::*; #(
  parameter int FRAME_IDX  = 0,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic frame_en,
  input  wire logic tok_vld_in,
  input  wire tok_t tok_in,
  output logic      tok_vld_r,
  output tok_t      tok_r,
  output logic      emit_vld,
  output res_t      emit
);

  localparam int UNIT      = frame_unit(FRAME_IDX);
  localparam int NEXT_UNIT = frame_unit(FRAME_IDX + 1);
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(NEXT_UNIT) - 64'd1) / 64'(NEXT_UNIT));

  logic [TIME_BITS-1:0]        bs_r, bs_nxt;
  logic [PRICE_BITS-1:0]       open_r, open_nxt;
  logic [PRICE_BITS-1:0]       high_r, high_nxt;
  logic [PRICE_BITS-1:0]       low_r, low_nxt;
  logic [PRICE_BITS-1:0]       close_r, close_nxt;
  logic [COUNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic [BAR_VOL_BITS-1:0]     vol_r, vol_nxt;

  logic [PRICE_BITS-1:0]       price_w;
  logic [RECIP_BITS-1:0]       qprod;
  logic [2*TIME_BITS-1:0]      aprod;
  logic [TIME_BITS-1:0]        aligned;
  logic [TIME_BITS:0]          bs_end;
  logic                        cnt_nz;
  logic                        outside;
  logic                        act;
  logic                        do_close;
  logic                        do_upd;
  logic [BAR_VOL_BITS:0]       vsum;
  logic [BAR_VOL_BITS-1:0]     vol_sat;
  tok_t                        tok_nxt;

  always_comb begin
    price_w  = PRICE_BITS'(tok_in.price);
    qprod    = RECIP_BITS'(tok_in.tod) * RECIP;
    aprod    = (2*TIME_BITS)'(tok_in.quot) * (2*TIME_BITS)'(UNIT);
    aligned  = aprod[TIME_BITS-1:0];
    bs_end   = {1'b0, bs_r} + (TIME_BITS+1)'(UNIT);
    cnt_nz   = (cnt_r != '0);
    outside  = (tok_in.tod < bs_r) || ({1'b0, tok_in.tod} >= bs_end);
    act      = tok_vld_in && adv;
    do_close = act && frame_en && cnt_nz && outside;
    do_upd   = act && frame_en && !tok_in.unchanged;

    vsum = {vol_r[BAR_VOL_BITS-1], vol_r}
         + {{(BAR_VOL_BITS+1-DELTA_BITS){tok_in.delta[DELTA_BITS-1]}}, tok_in.delta};
    if (vsum[BAR_VOL_BITS] != vsum[BAR_VOL_BITS-1]) begin
      vol_sat = vsum[BAR_VOL_BITS] ? VOL_MIN : VOL_MAX;
    end else begin
      vol_sat = vsum[BAR_VOL_BITS-1:0];
    end

    bs_nxt    = bs_r;
    open_nxt  = open_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    close_nxt = close_r;
    cnt_nxt   = cnt_r;
    vol_nxt   = vol_r;

    priority if (do_upd && (!cnt_nz || do_close)) begin
      bs_nxt    = aligned;
      open_nxt  = price_w;
      high_nxt  = price_w;
      low_nxt   = price_w;
      close_nxt = price_w;
      cnt_nxt   = COUNT_BITS'(1);
      vol_nxt   = {{(BAR_VOL_BITS-DELTA_BITS){tok_in.delta[DELTA_BITS-1]}}, tok_in.delta};
    end else if (do_upd) begin
      if (price_w > high_r) begin
        high_nxt = price_w;
      end
      if (price_w < low_r) begin
        low_nxt = price_w;
      end
      close_nxt = price_w;
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
      vol_nxt = vol_sat;
    end else if (do_close) begin
      cnt_nxt = '0;
      vol_nxt = '0;
    end

    tok_nxt      = tok_in;
    tok_nxt.quot = qprod[RECIP_SHIFT +: TIME_BITS];

    emit_vld               = do_close;
    emit                   = '0;
    emit.kind              = KIND_BAR;
    emit.frame             = FRAME_BITS'(FRAME_IDX);
    emit.bar_start         = bs_r;
    emit.open_price        = PRICE_IO_BITS'(open_r);
    emit.high_price        = PRICE_IO_BITS'(high_r);
    emit.low_price         = PRICE_IO_BITS'(low_r);
    emit.close_price       = PRICE_IO_BITS'(close_r);
    emit.tick_count        = cnt_r;
    emit.bar_volume        = vol_r;
    emit.volume_unchanged  = 1'b0;
    emit.last              = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      vol_r     <= '0;
      tok_vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vol_r <= vol_nxt;
      if (adv) begin
        tok_vld_r <= tok_vld_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    bs_r    <= bs_nxt;
    open_r  <= open_nxt;
    high_r  <= high_nxt;
    low_r   <= low_nxt;
    close_r <= close_nxt;
    if (act) begin
      tok_r <= tok_nxt;
    end
  end

  `ASSERT_CLK(a_empty_bar_no_volume, (cnt_r == '0) |-> (vol_r == '0), "empty bar holds volume")
  `ASSERT_CLK(a_high_over_low, (cnt_r != '0) |-> (high_r >= low_r), "bar high below low")
  `ASSERT_CLK(a_close_in_range, (cnt_r != '0) |-> ((close_r <= high_r) && (close_r >= low_r)), "bar close outside high and low")

endmodule

`default_nettype wire

/* bench/tb_multi_timeframe_ohlc_bar_builder.sv */
// self-checking bench for multi_timeframe_ohlc_bar_builder: directed tick table, then random
// market sessions under several frame masks, idle patterns and backpressure
// depends on mtf_ohlc_pkg and the block rtl
module tb_multi_timeframe_ohlc_bar_builder;
  import mtf_ohlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TABLE_ROWS = 20;
  localparam longint VOL_TOP = longint'($signed(VOL_MAX));
  localparam longint VOL_BOTTOM = longint'($signed(VOL_MIN));

  typedef struct packed {
    logic [TIME_BITS-1:0]      tod;
    logic [PRICE_IO_BITS-1:0]  price;
    logic [VOLUME_IN_BITS-1:0] vol;
    logic                      typed;
    logic                      unch;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MASK_BITS-1:0] cfg_frame_enable_mask = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TIME_BITS-1:0] in_time_of_day = '0;
  logic [PRICE_IO_BITS-1:0] in_last_price = '0;
  logic [VOLUME_IN_BITS-1:0] in_total_volume = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [FRAME_BITS-1:0] out_frame;
  logic [TIME_BITS-1:0] out_bar_start;
  logic [PRICE_IO_BITS-1:0] out_open_price;
  logic [PRICE_IO_BITS-1:0] out_high_price;
  logic [PRICE_IO_BITS-1:0] out_low_price;
  logic [PRICE_IO_BITS-1:0] out_close_price;
  logic [COUNT_BITS-1:0] out_tick_count;
  logic signed [BAR_VOL_BITS-1:0] out_bar_volume;
  logic out_volume_unchanged;
  logic out_last;

  // bar builder shadow state
  logic [MASK_BITS-1:0] frame_mask = MASK_RESET;
  logic [TIME_BITS-1:0] open_start [KNOWN_FRAMES];
  logic [PRICE_IO_BITS-1:0] open_px [KNOWN_FRAMES];
  logic [PRICE_IO_BITS-1:0] high_px [KNOWN_FRAMES];
  logic [PRICE_IO_BITS-1:0] low_px [KNOWN_FRAMES];
  logic [PRICE_IO_BITS-1:0] close_px [KNOWN_FRAMES];
  logic [COUNT_BITS-1:0] bar_ticks [KNOWN_FRAMES];
  logic signed [BAR_VOL_BITS-1:0] bar_vol [KNOWN_FRAMES];
  logic [VOLUME_IN_BITS-1:0] prev_volume = '0;

  res_t due_results [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int rx_hold = 0;

  int mk_time = 0;
  logic [PRICE_IO_BITS-1:0] mk_price = 32'd1000000;
  logic [VOLUME_IN_BITS-1:0] mk_vol = '0;

  tick_row_t tick_table [TABLE_ROWS] = '{
    '{17'd0,      32'd100,        31'd0,          1'b1, 1'b1},
    '{17'd0,      32'd0,          31'd10,         1'b0, 1'b0},
    '{17'd59,     32'hFFFFFFFF,   31'd20,         1'b0, 1'b0},
    '{17'd60,     32'd5,          31'd20,         1'b1, 1'b1},
    '{17'd60,     32'd7,          31'd30,         1'b0, 1'b0},
    '{17'd299,    32'd1,          31'h7FFFFFFF,   1'b0, 1'b0},
    '{17'd300,    32'd8,          31'd25,         1'b0, 1'b0},
    '{17'd300,    32'd9,          31'd25,         1'b1, 1'b1},
    '{17'd899,    32'h80000000,   31'd40,         1'b0, 1'b0},
    '{17'd900,    32'd3,          31'd41,         1'b0, 1'b0},
    '{17'd3599,   32'd12,         31'd42,         1'b0, 1'b0},
    '{17'd3600,   32'd11,         31'd43,         1'b0, 1'b0},
    '{17'd86399,  32'hFFFFFFFF,   31'h7FFFFFFF,   1'b0, 1'b0},
    '{17'd86400,  32'd0,          31'd0,          1'b0, 1'b0},
    '{17'd131071, 32'd55,         31'd1,          1'b0, 1'b0},
    '{17'd0,      32'd66,         31'd2,          1'b0, 1'b0},
    '{17'd30,     32'd66,         31'd2,          1'b1, 1'b1},
    '{17'd10,     32'd70,         31'd3,          1'b0, 1'b0},
    '{17'd65536,  32'hAAAAAAAA,   31'h55555555,   1'b0, 1'b0},
    '{17'd43690,  32'h55555555,   31'h2AAAAAAA,   1'b0, 1'b0}
  };

  multi_timeframe_ohlc_bar_builder u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_frame_enable_mask (cfg_frame_enable_mask),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_time_of_day        (in_time_of_day),
    .in_last_price         (in_last_price),
    .in_total_volume       (in_total_volume),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_frame             (out_frame),
    .out_bar_start         (out_bar_start),
    .out_open_price        (out_open_price),
    .out_high_price        (out_high_price),
    .out_low_price         (out_low_price),
    .out_close_price       (out_close_price),
    .out_tick_count        (out_tick_count),
    .out_bar_volume        (out_bar_volume),
    .out_volume_unchanged  (out_volume_unchanged),
    .out_last              (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int f = 0; f < KNOWN_FRAMES; f++) begin
      open_start[f] = '0;
      open_px[f] = '0;
      high_px[f] = '0;
      low_px[f] = '0;
      close_px[f] = '0;
      bar_ticks[f] = '0;
      bar_vol[f] = '0;
    end
  end

  // closes bars the tick leaves behind, then folds a tick with new volume into enabled open bars
  task automatic roll_bars(input logic [TIME_BITS-1:0] tod,
                           input logic [PRICE_IO_BITS-1:0] price,
                           input logic [VOLUME_IN_BITS-1:0] vol,
                           output res_t status);
    res_t closed;
    int unsigned span;
    longint delta;
    longint acc;
    logic still;
    still = (vol == prev_volume);
    delta = longint'(vol) - longint'(prev_volume);
    for (int f = 0; f < KNOWN_FRAMES; f++) begin
      if (f != 0 && !frame_mask[f-1]) continue;
      span = (f == 0) ? SEC_PER_MIN : (f == 1) ? 5 * SEC_PER_MIN :
             (f == 2) ? 15 * SEC_PER_MIN : SEC_PER_HOUR;
      if (tod / span != open_start[f] / span && bar_ticks[f] != 0) begin
        closed = '0;
        closed.kind = KIND_BAR;
        closed.frame = FRAME_BITS'(f);
        closed.bar_start = open_start[f];
        closed.open_price = open_px[f];
        closed.high_price = high_px[f];
        closed.low_price = low_px[f];
        closed.close_price = close_px[f];
        closed.tick_count = bar_ticks[f];
        closed.bar_volume = bar_vol[f];
        due_results.push_back(closed);
        bar_ticks[f] = '0;
        bar_vol[f] = '0;
      end
      if (still) continue;
      if (bar_ticks[f] == 0) begin
        open_px[f] = price;
        high_px[f] = price;
        low_px[f] = price;
        open_start[f] = TIME_BITS'((tod / span) * span);
      end
      if (price > high_px[f]) high_px[f] = price;
      if (price < low_px[f]) low_px[f] = price;
      close_px[f] = price;
      if (bar_ticks[f] != '1) bar_ticks[f] = bar_ticks[f] + 1'b1;
      acc = longint'(bar_vol[f]) + delta;
      if (acc > VOL_TOP) acc = VOL_TOP;
      if (acc < VOL_BOTTOM) acc = VOL_BOTTOM;
      bar_vol[f] = acc[BAR_VOL_BITS-1:0];
    end
    prev_volume = vol;
    status = '0;
    status.kind = KIND_STATUS;
    status.volume_unchanged = still;
    status.last = 1'b1;
  endtask

  function automatic string bar_text(input res_t r);
    return $sformatf({"kind=%0d frame=%0d start=%0d o=%h h=%h l=%h c=%h",
                      " n=%0d vol=%0d unch=%0d last=%0d"},
                     r.kind, r.frame, r.bar_start, r.open_price, r.high_price, r.low_price,
                     r.close_price, r.tick_count, r.bar_volume, r.volume_unchanged, r.last);
  endfunction

  task automatic settle();
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_frame_mask(input logic [MASK_BITS-1:0] mask);
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_frame_enable_mask = mask;
    do @(posedge clk); while (!cfg_ready);
    frame_mask = mask;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic offer_tick(input logic [TIME_BITS-1:0] tod,
                            input logic [PRICE_IO_BITS-1:0] price,
                            input logic [VOLUME_IN_BITS-1:0] vol,
                            input logic typed, input logic unch);
    res_t status;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_time_of_day = tod;
    in_last_price = price;
    in_total_volume = vol;
    do @(posedge clk); while (!in_ready);
    roll_bars(tod, price, vol, status);
    if (typed) status.volume_unchanged = unch;
    due_results.push_back(status);
    @(negedge clk);
  endtask

  task automatic run_market(input int ticks, input logic [MASK_BITS-1:0] mask,
                            input int gap, input int stall, input logic squeeze);
    logic [TIME_BITS-1:0] tod;
    logic [PRICE_IO_BITS-1:0] price;
    logic [VOLUME_IN_BITS-1:0] vol;
    int step;
    int pick;
    in_valid = 1'b0;
    write_frame_mask(mask);
    gap_pct = gap;
    stall_pct = stall;
    for (int i = 0; i < ticks; i++) begin
      if (squeeze && i == ticks / 4) rx_hold = 400;
      if (i == ticks / 2) begin
        in_valid = 1'b0;
        settle();
      end
      if ($urandom_range(0, 99) < 8) begin
        tod = TIME_BITS'($urandom_range(0, 131071));
        price = $urandom;
        vol = VOLUME_IN_BITS'($urandom);
      end else begin
        step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 40);
        if (mk_time + step > 131071) mk_time = $urandom_range(0, 600);
        else mk_time = mk_time + step;
        pick = $urandom_range(0, 99);
        if (pick < 4) mk_price = '0;
        else if (pick < 8) mk_price = '1;
        else mk_price = mk_price + 32'($urandom_range(0, 2000)) - 32'd1000;
        pick = $urandom_range(0, 99);
        if (pick < 25) mk_vol = mk_vol;
        else if (pick < 30) mk_vol = mk_vol - VOLUME_IN_BITS'($urandom_range(1, 5000));
        else mk_vol = mk_vol + VOLUME_IN_BITS'($urandom_range(1, 5000));
        tod = TIME_BITS'(mk_time);
        price = mk_price;
        vol = mk_vol;
      end
      offer_tick(tod, price, vol, 1'b0, 1'b0);
    end
    in_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      got.kind = out_kind;
      got.frame = out_frame;
      got.bar_start = out_bar_start;
      got.open_price = out_open_price;
      got.high_price = out_high_price;
      got.low_price = out_low_price;
      got.close_price = out_close_price;
      got.tick_count = out_tick_count;
      got.bar_volume = out_bar_volume;
      got.volume_unchanged = out_volume_unchanged;
      got.last = out_last;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %s", bar_text(got));
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.frame !== want.frame ||
            got.bar_start !== want.bar_start || got.open_price !== want.open_price ||
            got.high_price !== want.high_price || got.low_price !== want.low_price ||
            got.close_price !== want.close_price || got.tick_count !== want.tick_count ||
            got.bar_volume !== want.bar_volume ||
            got.volume_unchanged !== want.volume_unchanged || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected: %s", bar_text(want));
            $display("mismatch actual:   %s", bar_text(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("multi_timeframe_ohlc_bar_builder regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_frame_mask(MASK_RESET);
    for (int r = 0; r < TABLE_ROWS; r++) begin
      offer_tick(tick_table[r].tod, tick_table[r].price, tick_table[r].vol,
                 tick_table[r].typed, tick_table[r].unch);
    end
    run_market(75, 3'b000, 0, 0, 1'b0);
    run_market(75, 3'b111, 84, 0, 1'b0);
    run_market(75, 3'b101, 0, 84, 1'b0);
    run_market(75, MASK_BITS'($urandom_range(0, 7)), 17, 17, 1'b0);
    run_market(70, 3'b010, 0, 0, 1'b1);
    run_market(75, 3'b111, 17, 17, 1'b0);
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("multi_timeframe_ohlc_bar_builder regression: pass");
    end else begin
      $display("multi_timeframe_ohlc_bar_builder regression: fail");
    end
    $finish;
  end

endmodule
